// ----- sv/lfme_pkg.sv -----
// ============================================================================
// lfme_pkg: shared types and constants of the layered field map evaluator
// Input and output words, the pipeline context, register and kind codes.
// ============================================================================
package lfme_pkg;

    // Operation codes of an input word
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_MAP_OFFSET       = 3'd0;
    localparam logic [2:0] REG_BARREL_Z_LIMIT   = 3'd1;
    localparam logic [2:0] REG_ENDCAP_Z_START   = 3'd2;
    localparam logic [2:0] REG_ENDCAP_R_FLOOR   = 3'd3;
    localparam logic [2:0] REG_LAYER_PITCH      = 3'd4;
    localparam logic [2:0] REG_BARREL_DEPTH     = 3'd5;
    localparam logic [2:0] REG_BARREL_IRON      = 3'd6;
    localparam logic [2:0] REG_ENDCAP_GAP       = 3'd7;

    localparam logic [30:0] PITCH_RESET = 31'd65536;

    // Coefficient kinds: barrel kinds are codes 0..9, endcap kinds start at 10
    localparam int BAR_KINDS = 10;
    localparam int EC_KINDS  = 6;
    localparam logic [3:0] KIND_EC_BASE = 4'd10;

    localparam int BK_Z_BP     = 0;
    localparam int BK_R_BP     = 1;
    localparam int BK_Z_SLOPE1 = 2;
    localparam int BK_Z_ICPT1  = 3;
    localparam int BK_Z_SLOPE2 = 4;
    localparam int BK_Z_ICPT2  = 5;
    localparam int BK_R_SLOPE1 = 6;
    localparam int BK_R_ICPT1  = 7;
    localparam int BK_R_SLOPE2 = 8;
    localparam int BK_R_ICPT2  = 9;

    localparam int EK_Z_BP    = 0;
    localparam int EK_R_BP    = 1;
    localparam int EK_Z_SLOPE = 2;
    localparam int EK_Z_ICPT  = 3;
    localparam int EK_R_SLOPE = 4;
    localparam int EK_R_ICPT  = 5;

    // Octant constants in Q0.16
    localparam logic [15:0] COS_PI8  = 16'd60547;
    localparam logic [15:0] COS_3PI8 = 16'd25080;
    localparam logic [15:0] COS_PI4  = 16'd46341;

    // Layer quotient bits: covers any layer count up to 32 plus the overflow layer
    localparam int QW = 6;
    // Root bits and projection quotient bits
    localparam int SQ_STEPS = 32;
    localparam int PJ_STEPS = 32;

    localparam logic signed [65:0] S32_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] S32_MIN = -66'sh0_8000_0000;

    typedef struct packed {
        logic               op;
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [31:0] z_pos;
        logic [3:0]         word_kind;
        logic [7:0]         word_slot;
        logic signed [31:0] word_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
    } t_out_word;

    // Context that travels down the pipeline; each stage fills its part
    typedef struct packed {
        logic               op;
        logic [3:0]         kind;
        logic [7:0]         slot;
        logic signed [31:0] value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [32:0]        az;
        logic [63:0]        sq_x;
        logic [63:0]        sq_y;
        logic [63:0]        rad_v;
        logic [63:0]        rad_res;
        logic [31:0]        r;
        logic [47:0]        c1;
        logic [47:0]        c3;
        logic [48:0]        diag_p;
        logic               in_bar;
        logic               in_ec;
        logic [33:0]        dv;
        logic               big;
        logic [QW-1:0]      q;
        logic               hit_b;
        logic               hit_e;
        logic [4:0]         layer;
        logic               iron;
        logic signed [31:0] slope_r;
        logic signed [31:0] icpt_r;
        logic signed [31:0] slope_z;
        logic signed [31:0] icpt_z;
        logic [31:0]        pos;
        logic               rad_on;
        logic               z_on;
        logic signed [64:0] pr;
        logic signed [64:0] pz;
        logic signed [31:0] br;
        logic signed [31:0] bz;
        logic signed [64:0] px;
        logic signed [64:0] py;
        logic [62:0]        mx;
        logic [62:0]        my;
        logic               neg_x;
        logic               neg_y;
        logic [31:0]        qx;
        logic [31:0]        qy;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } t_ctx;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- sv/layered_field_map_evaluator.sv -----
// ============================================================================
// layered_field_map_evaluator: piecewise-linear field map of a layered yoke
// Table loads and point evaluations share one fully pipelined datapath.
// ============================================================================
// One word enters per clock unless the output is stalled; a load word
// walks the same pipeline, writes its coefficient when it reaches the
// table stage and gives no output word. The depth is set by the radius
// root (32 stages, one root bit each), the layer divider (6 stages) and the
// x/y projection divider (32 stages, one quotient bit each). Coefficient
// tables are plain memories with no reset or clearing pass: an entry must be
// loaded before a point reads it. Output stall freezes the whole pipeline.
module layered_field_map_evaluator
    import lfme_pkg::*;
#(
    parameter int BARREL_LAYERS   = 15,
    parameter int ENDCAP_LAYERS   = 14,
    parameter int RADIAL_SEGMENTS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Stage numbering
    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_S0  = 3;
    localparam int ST_SL  = ST_S0 + SQ_STEPS - 1;
    localparam int ST_D   = ST_SL + 1;
    localparam int ST_E   = ST_D + 1;
    localparam int ST_F   = ST_E + 1;
    localparam int ST_Q0  = ST_F + 1;
    localparam int ST_QL  = ST_Q0 + QW - 1;
    localparam int ST_H   = ST_QL + 1;
    localparam int ST_SEL = ST_H + 1;
    localparam int ST_I   = ST_SEL + 1;
    localparam int ST_J   = ST_I + 1;
    localparam int ST_K   = ST_J + 1;
    localparam int ST_L   = ST_K + 1;
    localparam int ST_X0  = ST_L + 1;
    localparam int ST_XL  = ST_X0 + PJ_STEPS - 1;
    localparam int ST_OUT = ST_XL + 1;
    localparam int NST    = ST_OUT + 1;

    localparam int EC_ROWS = 2 * (ENDCAP_LAYERS + 1);
    localparam int EC_SLOTS = EC_ROWS * RADIAL_SEGMENTS;
    localparam int BL_W  = (BARREL_LAYERS > 1) ? $clog2(BARREL_LAYERS) : 1;
    localparam int ECR_W = $clog2(EC_ROWS);
    localparam int SEG_W = (RADIAL_SEGMENTS > 1) ? $clog2(RADIAL_SEGMENTS) : 1;

    // Configuration registers
    logic signed [31:0] r_map_offset;
    logic [30:0]        r_bar_z_limit;
    logic [30:0]        r_ec_z_start;
    logic [30:0]        r_ec_r_floor;
    logic [30:0]        r_pitch;
    logic [30:0]        r_bar_depth;
    logic [30:0]        r_bar_iron;
    logic [30:0]        r_ec_gap;
    logic [30:0]        pitch;

    logic               cfg_we;

    // Pipeline
    t_ctx               r_p [0:NST-1];
    t_ctx               n_p [0:NST-1];
    logic [NST-1:0]     r_pv;
    logic               en;

    // Table stage
    logic               g_hit_b;
    logic               g_hit_e;
    logic               g_iron;
    logic [4:0]         g_layer;
    logic [BL_W-1:0]    bar_raddr;
    logic [ECR_W-1:0]   ec_raddr;
    logic               ld;
    logic               bar_we;
    logic               ec_we;
    logic [3:0]         bar_wkind;
    logic [2:0]         ec_wkind;
    logic [BL_W-1:0]    bar_waddr;
    logic [ECR_W-1:0]   ec_wrow;
    logic [SEG_W-1:0]   ec_wseg;
    logic [31:0]        rd_bar [0:BAR_KINDS-1];
    logic [31:0]        rd_ec [0:EC_KINDS-1][0:RADIAL_SEGMENTS-1];

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign pitch  = (r_pitch == '0) ? 31'd1 : r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_offset  <= '0;
            r_bar_z_limit <= '0;
            r_ec_z_start  <= '0;
            r_ec_r_floor  <= '0;
            r_pitch       <= PITCH_RESET;
            r_bar_depth   <= '0;
            r_bar_iron    <= '0;
            r_ec_gap      <= '0;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_MAP_OFFSET:     r_map_offset  <= pwdata;
                REG_BARREL_Z_LIMIT: r_bar_z_limit <= pwdata[30:0];
                REG_ENDCAP_Z_START: r_ec_z_start  <= pwdata[30:0];
                REG_ENDCAP_R_FLOOR: r_ec_r_floor  <= pwdata[30:0];
                REG_LAYER_PITCH:    r_pitch       <= pwdata[30:0];
                REG_BARREL_DEPTH:   r_bar_depth   <= pwdata[30:0];
                REG_BARREL_IRON:    r_bar_iron    <= pwdata[30:0];
                REG_ENDCAP_GAP:     r_ec_gap      <= pwdata[30:0];
            endcase
        end
    end

    // Read back a register
    always_comb begin
        unique case (paddr[4:2])
            REG_MAP_OFFSET:     prdata = r_map_offset;
            REG_BARREL_Z_LIMIT: prdata = {1'b0, r_bar_z_limit};
            REG_ENDCAP_Z_START: prdata = {1'b0, r_ec_z_start};
            REG_ENDCAP_R_FLOOR: prdata = {1'b0, r_ec_r_floor};
            REG_LAYER_PITCH:    prdata = {1'b0, r_pitch};
            REG_BARREL_DEPTH:   prdata = {1'b0, r_bar_depth};
            REG_BARREL_IRON:    prdata = {1'b0, r_bar_iron};
            REG_ENDCAP_GAP:     prdata = {1'b0, r_ec_gap};
        endcase
    end

    // Advance everything unless a finished word is held by the sink
    assign o_valid = r_pv[ST_OUT] && (r_p[ST_OUT].op == OP_EVAL);
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign o_data.field_x = r_p[ST_OUT].fx;
    assign o_data.field_y = r_p[ST_OUT].fy;
    assign o_data.field_z = r_p[ST_OUT].bz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (en) begin
            r_pv <= {r_pv[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    // Layer decision, table addresses and load decode
    always_comb begin
        logic [33:0] rem_b;
        t_ctx        rq;
        rq      = r_p[ST_QL];
        rem_b   = rq.dv;
        g_layer = rq.q[4:0];
        if (rq.in_bar && (rq.q == QW'(BARREL_LAYERS))) begin
            // outermost plate: last layer at offset zero
            g_layer = 5'(BARREL_LAYERS - 1);
            rem_b   = '0;
        end
        g_hit_b = rq.in_bar && !rq.big && (rq.q <= QW'(BARREL_LAYERS))
                  && (rem_b < {3'b0, r_bar_iron});
        g_hit_e = rq.in_ec && !rq.big && (rq.q < QW'(ENDCAP_LAYERS));
        g_iron  = rq.dv > {3'b0, r_ec_gap};
        bar_raddr = g_layer[BL_W-1:0];
        ec_raddr  = ECR_W'(g_layer) + (g_iron ? ECR_W'(ENDCAP_LAYERS + 1) : '0);

        ld        = r_pv[ST_QL] && (rq.op == OP_LOAD);
        bar_wkind = rq.kind;
        bar_waddr = rq.slot[BL_W-1:0];
        bar_we    = ld && (rq.kind < 4'(BAR_KINDS)) && (rq.slot < 8'(BARREL_LAYERS));
        ec_wkind  = 3'(rq.kind - KIND_EC_BASE);
        ec_we     = ld && (rq.kind >= KIND_EC_BASE) && (int'(rq.slot) < EC_SLOTS);
        ec_wrow   = '0;
        ec_wseg   = '0;
        for (int w = 0; w < EC_ROWS; w++) begin
            if ((int'(rq.slot) >= w * RADIAL_SEGMENTS)
                && (int'(rq.slot) < (w + 1) * RADIAL_SEGMENTS)) begin
                ec_wrow = ECR_W'(w);
                ec_wseg = SEG_W'(int'(rq.slot) - w * RADIAL_SEGMENTS);
            end
        end
    end

    // Barrel coefficient memories, one per kind
    for (genvar k = 0; k < BAR_KINDS; k++) begin : g_bar
        logic [31:0] mem [0:BARREL_LAYERS-1];
        always_ff @(posedge i_clk) begin
            if (en && bar_we && (bar_wkind == 4'(k))) begin
                mem[bar_waddr] <= r_p[ST_QL].value;
            end
            if (en) begin
                rd_bar[k] <= mem[bar_raddr];
            end
        end
    end

    // Endcap coefficient memories, one per kind and segment
    for (genvar k = 0; k < EC_KINDS; k++) begin : g_ec_kind
        for (genvar s = 0; s < RADIAL_SEGMENTS; s++) begin : g_ec_seg
            logic [31:0] mem [0:EC_ROWS-1];
            always_ff @(posedge i_clk) begin
                if (en && ec_we && (ec_wkind == 3'(k)) && (ec_wseg == SEG_W'(s))) begin
                    mem[ec_wrow] <= r_p[ST_QL].value;
                end
                if (en) begin
                    rd_ec[k][s] <= mem[ec_raddr];
                end
            end
        end
    end

    // Stage logic
    always_comb begin
        logic [63:0]        sq_bit;
        logic [63:0]        sq_try;
        logic [36:0]        ly_try;
        logic [62:0]        pj_try;
        logic [47:0]        ax_sh;
        logic [32:0]        meas;
        logic signed [34:0] d_bar;
        logic signed [35:0] d_ec;
        logic               bar_reg;
        logic               z_hi;
        logic               r_hi;
        logic               hit_r;
        logic               hit_z;
        logic signed [32:0] bn;
        logic signed [65:0] qv;
        t_ctx               c;
        int                 k;

        for (int s = 1; s < NST; s++) begin
            n_p[s] = r_p[s-1];
        end

        // Take in the word and shift z
        c       = '0;
        c.op    = i_data.op;
        c.kind  = i_data.word_kind;
        c.slot  = i_data.word_slot;
        c.value = i_data.word_value;
        c.x     = i_data.x_pos;
        c.y     = i_data.y_pos;
        c.z     = $signed({{2{i_data.z_pos[31]}}, i_data.z_pos})
                  - $signed({{2{r_map_offset[31]}}, r_map_offset});
        n_p[ST_A] = c;

        // Magnitudes and squares
        c      = r_p[ST_A];
        c.ax   = c.x[31] ? 32'(-c.x) : 32'(c.x);
        c.ay   = c.y[31] ? 32'(-c.y) : 32'(c.y);
        c.az   = c.z[33] ? 33'(-c.z) : c.z[32:0];
        c.sq_x = 64'(c.ax) * 64'(c.ax);
        c.sq_y = 64'(c.ay) * 64'(c.ay);
        n_p[ST_B] = c;

        // Radicand
        c         = r_p[ST_B];
        c.rad_v   = c.sq_x + c.sq_y;
        c.rad_res = '0;
        n_p[ST_C] = c;

        // Root, one bit a stage
        for (int i = 0; i < SQ_STEPS; i++) begin
            c      = r_p[ST_S0 + i - 1];
            sq_bit = 64'(1) << (62 - 2 * i);
            sq_try = c.rad_res + sq_bit;
            if (c.rad_v >= sq_try) begin
                c.rad_v   = c.rad_v - sq_try;
                c.rad_res = (c.rad_res >> 1) + sq_bit;
            end else begin
                c.rad_res = c.rad_res >> 1;
            end
            n_p[ST_S0 + i] = c;
        end

        // Octant products
        c        = r_p[ST_SL];
        c.r      = c.rad_res[31:0];
        c.c1     = 48'(c.r) * 48'(COS_PI8);
        c.c3     = 48'(c.r) * 48'(COS_3PI8);
        c.diag_p = (49'(c.ax) + 49'(c.ay)) * 49'(COS_PI4);
        n_p[ST_D] = c;

        // Plate depth, region and dividend
        c     = r_p[ST_D];
        ax_sh = {c.ax, 16'b0};
        if (ax_sh < c.c1) begin
            meas = (ax_sh < c.c3) ? {1'b0, c.ay} : c.diag_p[48:16];
        end else begin
            meas = {1'b0, c.ax};
        end
        d_bar   = $signed({2'b0, meas}) - $signed({4'b0, r_bar_depth});
        d_ec    = $signed({3'b0, c.az})
                  - ($signed({5'b0, r_ec_z_start}) - $signed({5'b0, r_ec_gap}));
        bar_reg = (c.r != '0) && (c.az < {2'b0, r_bar_z_limit});
        c.in_bar = (c.op == OP_EVAL) && bar_reg && !d_bar[34];
        c.in_ec  = (c.op == OP_EVAL) && !bar_reg && (c.r != '0)
                   && (c.az > {2'b0, r_ec_z_start}) && (c.r > {1'b0, r_ec_r_floor})
                   && !d_ec[35];
        c.dv     = bar_reg ? d_bar[33:0] : d_ec[33:0];
        n_p[ST_E] = c;

        // Drop layers past the quotient range
        c     = r_p[ST_E];
        c.big = {3'b0, c.dv} >= (37'(pitch) << QW);
        c.q   = '0;
        n_p[ST_F] = c;

        // Layer divider, one quotient bit a stage
        for (int i = 0; i < QW; i++) begin
            c      = r_p[ST_Q0 + i - 1];
            k      = QW - 1 - i;
            ly_try = 37'(pitch) << k;
            if ({3'b0, c.dv} >= ly_try) begin
                c.dv   = c.dv - ly_try[33:0];
                c.q[k] = 1'b1;
            end
            n_p[ST_Q0 + i] = c;
        end

        // Layer decision travels with the table read
        c       = r_p[ST_QL];
        c.hit_b = g_hit_b;
        c.hit_e = g_hit_e;
        c.layer = g_layer;
        c.iron  = g_iron;
        n_p[ST_H] = c;

        // Pick linear pieces
        c    = r_p[ST_H];
        z_hi = $signed({1'b0, c.az}) > $signed({{2{rd_bar[BK_Z_BP][31]}}, rd_bar[BK_Z_BP]});
        r_hi = $signed({1'b0, c.az}) > $signed({{2{rd_bar[BK_R_BP][31]}}, rd_bar[BK_R_BP]});
        hit_r = 1'b0;
        hit_z = 1'b0;
        if (c.hit_b) begin
            c.pos     = c.az[31:0];
            c.slope_r = r_hi ? rd_bar[BK_R_SLOPE2] : rd_bar[BK_R_SLOPE1];
            c.icpt_r  = r_hi ? rd_bar[BK_R_ICPT2] : rd_bar[BK_R_ICPT1];
            c.slope_z = z_hi ? rd_bar[BK_Z_SLOPE2] : rd_bar[BK_Z_SLOPE1];
            c.icpt_z  = z_hi ? rd_bar[BK_Z_ICPT2] : rd_bar[BK_Z_ICPT1];
        end else begin
            c.pos     = c.r;
            c.slope_r = '0;
            c.icpt_r  = '0;
            c.slope_z = '0;
            c.icpt_z  = '0;
            // first segment whose breakpoint lies above r wins
            for (int j = RADIAL_SEGMENTS - 1; j >= 0; j--) begin
                if ($signed({2'b0, c.r})
                    < $signed({{2{rd_ec[EK_R_BP][j][31]}}, rd_ec[EK_R_BP][j]})) begin
                    hit_r     = 1'b1;
                    c.slope_r = rd_ec[EK_R_SLOPE][j];
                    c.icpt_r  = rd_ec[EK_R_ICPT][j];
                end
                if ($signed({2'b0, c.r})
                    < $signed({{2{rd_ec[EK_Z_BP][j][31]}}, rd_ec[EK_Z_BP][j]})) begin
                    hit_z     = 1'b1;
                    c.slope_z = rd_ec[EK_Z_SLOPE][j];
                    c.icpt_z  = rd_ec[EK_Z_ICPT][j];
                end
            end
        end
        c.rad_on = c.hit_b || (c.hit_e && hit_r);
        c.z_on   = c.hit_b || (c.hit_e && hit_z);
        n_p[ST_SEL] = c;

        // Slope times position
        c    = r_p[ST_SEL];
        c.pr = c.slope_r * $signed({1'b0, c.pos});
        c.pz = c.slope_z * $signed({1'b0, c.pos});
        n_p[ST_I] = c;

        // Add intercepts and clamp
        c    = r_p[ST_I];
        c.br = c.rad_on ? sat32($signed({{34{c.icpt_r[31]}}, c.icpt_r})
                                + ($signed({c.pr[64], c.pr}) >>> 16)) : '0;
        c.bz = c.z_on ? sat32($signed({{34{c.icpt_z[31]}}, c.icpt_z})
                              + ($signed({c.pz[64], c.pz}) >>> 16)) : '0;
        n_p[ST_J] = c;

        // Flip for negative z and scale by x and y
        c    = r_p[ST_J];
        bn   = c.z[33] ? -$signed({c.br[31], c.br}) : $signed({c.br[31], c.br});
        c.px = bn * c.x;
        c.py = bn * c.y;
        n_p[ST_K] = c;

        // Split into sign and magnitude
        c       = r_p[ST_K];
        c.neg_x = c.px[64];
        c.neg_y = c.py[64];
        c.mx    = c.px[64] ? 63'(-c.px) : c.px[62:0];
        c.my    = c.py[64] ? 63'(-c.py) : c.py[62:0];
        c.qx    = '0;
        c.qy    = '0;
        n_p[ST_L] = c;

        // Projection dividers, one quotient bit a stage
        for (int i = 0; i < PJ_STEPS; i++) begin
            c      = r_p[ST_X0 + i - 1];
            k      = PJ_STEPS - 1 - i;
            pj_try = 63'(c.r) << k;
            if (c.mx >= pj_try) begin
                c.mx    = c.mx - pj_try;
                c.qx[k] = 1'b1;
            end
            if (c.my >= pj_try) begin
                c.my    = c.my - pj_try;
                c.qy[k] = 1'b1;
            end
            n_p[ST_X0 + i] = c;
        end

        // Restore sign and clamp
        c    = r_p[ST_XL];
        qv   = $signed({34'b0, c.qx});
        c.fx = c.rad_on ? sat32(c.neg_x ? -qv : qv) : '0;
        qv   = $signed({34'b0, c.qy});
        c.fy = c.rad_on ? sat32(c.neg_y ? -qv : qv) : '0;
        n_p[ST_OUT] = c;
    end

    // Checks
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv[ST_SL] |-> (r_p[ST_SL].rad_v <= {r_p[ST_SL].rad_res[62:0], 1'b0}))
        else $error("root remainder exceeds twice the root");

    a_layer_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv[ST_QL] && !r_p[ST_QL].big |-> ({3'b0, r_p[ST_QL].dv} < 37'(pitch)))
        else $error("layer remainder not below pitch");

    a_region_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv[ST_H] |-> !(r_p[ST_H].hit_b && r_p[ST_H].hit_e))
        else $error("barrel and endcap both hit");

    a_proj_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv[ST_XL] && r_p[ST_XL].rad_on |-> (r_p[ST_XL].qx <= 32'h8000_0000))
        else $error("projection quotient beyond field range");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

endmodule

// ----- sim/layered_field_map_evaluator_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// layered_field_map_evaluator_tb: self-checking bench of the field map block
// Fills both coefficient tables, then drives directed and random point
// evaluations and table loads through several geometry settings. A local
// fixed-point predictor works out each field word, and a checker compares
// every output word with the oldest expected one. Both sides idle at random.
// ============================================================================
module layered_field_map_evaluator_tb
    import lfme_pkg::*;
;

    localparam int BL      = 15;
    localparam int EL      = 14;
    localparam int RS      = 5;
    localparam int EC_HALF = (EL + 1) * RS;
    localparam int EC_SLOTS = 2 * EC_HALF;
    localparam int CM      = 65536;
    localparam int LATENCY = 100;
    localparam int LIMIT   = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_word    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_word   o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    layered_field_map_evaluator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Mirror of the block's registers and tables
    longint map_offset_q, bar_zlim_q, ec_zstart_q, ec_rfloor_q;
    longint pitch_q, bar_depth_q, bar_iron_q, ec_gap_q;
    int     bar_tab [BAR_KINDS][BL];
    int     ec_tab  [EC_KINDS][EC_SLOTS];

    t_out_word fields_due [$];
    int        errors = 0;
    int        cycles = 0;
    bit        calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("layered_field_map_evaluator test failed");
            $finish;
        end
    end

    // Stall the output side at random
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint root64(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // One linear piece, product floored towards minus infinity
    function automatic longint line_at(int icpt, int slope, longint pos);
        longint p, q;
        p = longint'(slope) * pos;
        q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
        return clamp32(longint'(icpt) + q);
    endfunction

    function automatic t_out_word field_at(t_in_word w);
        longint x, y, z, ax, ay, az, r, pitch, br, bz, meas, d, lay, dz, base;
        logic [63:0] ux, uy;
        bit radial;
        t_out_word o;
        br = 0;
        bz = 0;
        radial = 0;
        x = w.x_pos;
        y = w.y_pos;
        z = longint'(w.z_pos) - map_offset_q;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        ux = ax;
        uy = ay;
        r = root64(ux * ux + uy * uy);
        pitch = pitch_q != 0 ? pitch_q : 1;
        if (r != 0 && az < bar_zlim_q) begin
            // Pick the octagon face the point lies against
            if (ax * 65536 < longint'(COS_PI8) * r) begin
                if (ax * 65536 < longint'(COS_3PI8) * r) meas = ay;
                else meas = ((ax + ay) * longint'(COS_PI4)) / 65536;
            end else begin
                meas = ax;
            end
            d = meas - bar_depth_q;
            if (d >= 0) begin
                lay = d / pitch;
                if (lay <= BL) begin
                    if (lay == BL) begin
                        lay = BL - 1;
                        d = lay * pitch;
                    end
                    if (d - lay * pitch < bar_iron_q) begin
                        br = (az > bar_tab[BK_R_BP][lay])
                            ? line_at(bar_tab[BK_R_ICPT2][lay], bar_tab[BK_R_SLOPE2][lay], az)
                            : line_at(bar_tab[BK_R_ICPT1][lay], bar_tab[BK_R_SLOPE1][lay], az);
                        bz = (az > bar_tab[BK_Z_BP][lay])
                            ? line_at(bar_tab[BK_Z_ICPT2][lay], bar_tab[BK_Z_SLOPE2][lay], az)
                            : line_at(bar_tab[BK_Z_ICPT1][lay], bar_tab[BK_Z_SLOPE1][lay], az);
                        radial = 1;
                    end
                end
            end
        end else if (r != 0 && az > ec_zstart_q && r > ec_rfloor_q) begin
            dz = az - (ec_zstart_q - ec_gap_q);
            if (dz >= 0) begin
                lay = dz / pitch;
                if (lay < EL) begin
                    base = lay * RS;
                    if (dz - pitch * lay > ec_gap_q) base += EC_HALF;
                    // First segment whose breakpoint lies beyond r
                    for (int j = 0; j < RS; j++) begin
                        if (r < ec_tab[EK_R_BP][base + j]) begin
                            br = line_at(ec_tab[EK_R_ICPT][base + j],
                                         ec_tab[EK_R_SLOPE][base + j], r);
                            radial = 1;
                            break;
                        end
                    end
                    for (int j = 0; j < RS; j++) begin
                        if (r < ec_tab[EK_Z_BP][base + j]) begin
                            bz = line_at(ec_tab[EK_Z_ICPT][base + j],
                                         ec_tab[EK_Z_SLOPE][base + j], r);
                            break;
                        end
                    end
                end
            end
        end
        o.field_x = '0;
        o.field_y = '0;
        if (radial) begin
            if (z < 0) br = -br;
            o.field_x = 32'(clamp32((br * x) / r));
            o.field_y = 32'(clamp32((br * y) / r));
        end
        o.field_z = 32'(bz);
        return o;
    endfunction

    // Apply one accepted word to the mirror
    function automatic void absorb_word(t_in_word w);
        if (w.op == OP_LOAD) begin
            if (w.word_kind < KIND_EC_BASE) begin
                if (w.word_slot < BL) bar_tab[w.word_kind][w.word_slot] = w.word_value;
            end else if (w.word_slot < EC_SLOTS) begin
                ec_tab[w.word_kind - KIND_EC_BASE][w.word_slot] = w.word_value;
            end
        end else begin
            fields_due.push_back(field_at(w));
        end
    endfunction

    // Check each output word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (fields_due.size() == 0) begin
                $error("unexpected output word %h", o_data);
                errors++;
            end else begin
                e = fields_due.pop_front();
                if (o_data.field_x !== e.field_x) begin
                    $error("field_x: expected %0d, got %0d", e.field_x, o_data.field_x);
                    errors++;
                end
                if (o_data.field_y !== e.field_y) begin
                    $error("field_y: expected %0d, got %0d", e.field_y, o_data.field_y);
                    errors++;
                end
                if (o_data.field_z !== e.field_z) begin
                    $error("field_z: expected %0d, got %0d", e.field_z, o_data.field_z);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(t_in_word w);
        while (!calm && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_word(w);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic settle();
        i_valid <= 1'b0;
        while (fields_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_MAP_OFFSET:     map_offset_q = longint'(signed'(val));
            REG_BARREL_Z_LIMIT: bar_zlim_q   = val[30:0];
            REG_ENDCAP_Z_START: ec_zstart_q  = val[30:0];
            REG_ENDCAP_R_FLOOR: ec_rfloor_q  = val[30:0];
            REG_LAYER_PITCH:    pitch_q      = val[30:0];
            REG_BARREL_DEPTH:   bar_depth_q  = val[30:0];
            REG_BARREL_IRON:    bar_iron_q   = val[30:0];
            default:            ec_gap_q     = val[30:0];
        endcase
    endtask

    task automatic set_geometry(int off, int zlim, int zst, int rfl, int pit,
                                int dep, int iron, int gap);
        reg_write(REG_MAP_OFFSET, off);
        reg_write(REG_BARREL_Z_LIMIT, zlim);
        reg_write(REG_ENDCAP_Z_START, zst);
        reg_write(REG_ENDCAP_R_FLOOR, rfl);
        reg_write(REG_LAYER_PITCH, pit);
        reg_write(REG_BARREL_DEPTH, dep);
        reg_write(REG_BARREL_IRON, iron);
        reg_write(REG_ENDCAP_GAP, gap);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_in_word point(int x, int y, int z);
        t_in_word w;
        w.op         = OP_EVAL;
        w.x_pos      = x;
        w.y_pos      = y;
        w.z_pos      = z;
        w.word_kind  = $urandom;
        w.word_slot  = $urandom;
        w.word_value = $urandom;
        return w;
    endfunction

    function automatic t_in_word load(int kind, int slot, int val);
        t_in_word w;
        w.op         = OP_LOAD;
        w.x_pos      = $urandom;
        w.y_pos      = $urandom;
        w.z_pos      = $urandom;
        w.word_kind  = kind;
        w.word_slot  = slot;
        w.word_value = val;
        return w;
    endfunction

    // Breakpoints within the yoke, coefficients small or full range
    function automatic int coef(bit is_bp);
        if (is_bp) return $urandom_range(0, 500 * CM);
        if ($urandom_range(3) == 0) return $urandom;
        return int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endfunction

    function automatic int spread(int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    // Mostly points around the yoke, with some fully random noise
    function automatic t_in_word rand_point();
        if ($urandom_range(9) == 0) return point($urandom, $urandom, $urandom);
        return point(spread(420 * CM), spread(420 * CM),
                     int'(map_offset_q) + spread(int'(ec_zstart_q) + 160 * CM));
    endfunction

    function automatic t_in_word rand_load();
        int kind;
        kind = $urandom_range(15);
        return load(kind, $urandom_range(255),
                    coef(kind == BK_Z_BP || kind == BK_R_BP ||
                         kind == KIND_EC_BASE + EK_Z_BP || kind == KIND_EC_BASE + EK_R_BP));
    endfunction

    task automatic test_table_fill();
        for (int k = 0; k < BAR_KINDS; k++)
            for (int s = 0; s < BL; s++)
                send_word(load(k, s, coef(k == BK_Z_BP || k == BK_R_BP)));
        for (int k = 0; k < EC_KINDS; k++)
            for (int s = 0; s < EC_SLOTS; s++)
                send_word(load(KIND_EC_BASE + k, s, coef(k == EK_Z_BP || k == EK_R_BP)));
        settle();
    endtask

    task automatic test_directed();
        int outer;
        set_geometry(5 * CM, 300 * CM, 330 * CM, 50 * CM, 10 * CM, 200 * CM, 6 * CM, 4 * CM);
        outer = 200 * CM + 15 * 10 * CM + CM;
        // zero radius, all three octant faces, outermost layer, negative z
        send_word(point(0, 0, 5 * CM));
        send_word(point(203 * CM, 0, 50 * CM));
        send_word(point(0, -204 * CM, 80 * CM));
        send_word(point(160 * CM, 160 * CM, 100 * CM));
        send_word(point(outer, 0, 20 * CM));
        send_word(point(-outer, CM, -120 * CM));
        send_word(point(212 * CM, 3 * CM, -250 * CM));
        send_word(point(100 * CM, 50 * CM, 20 * CM));
        // endcap gap, iron, no matching segment, beyond the last layer
        send_word(point(120 * CM, 80 * CM, 337 * CM));
        send_word(point(120 * CM, 80 * CM, 342 * CM));
        send_word(point(-90 * CM, 200 * CM, -365 * CM));
        send_word(point(30 * CM, 20 * CM, 350 * CM));
        send_word(point(32'sh7FFF_FFFF, 0, 340 * CM));
        send_word(point(100 * CM, 100 * CM, 700 * CM));
        // coordinate extremes and the gap between regions
        send_word(point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_word(point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_word(point(32'sh8000_0000, 5, 0));
        send_word(point(150 * CM, 150 * CM, 315 * CM));
        // loads beyond the end of each table are dropped
        send_word(load(BK_R_ICPT2, BL, 32'sh7FFF_FFFF));
        send_word(load(KIND_EC_BASE + EK_R_ICPT, 255, 32'sh8000_0000));
        send_word(point(205 * CM, 2 * CM, 10 * CM));
        settle();
    endtask

    task automatic random_burst(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 20) send_word(rand_load());
            else send_word(rand_point());
        end
    endtask

    task automatic test_random_nominal();
        random_burst(100);
        calm = 1'b1;
        random_burst(80);
        calm = 1'b0;
        settle();
    endtask

    task automatic test_random_shifted();
        set_geometry(-120 * CM, 250 * CM, 250 * CM, 0, 7 * CM, 150 * CM, 7 * CM, 0);
        random_burst(180);
        settle();
    endtask

    task automatic test_random_extremes();
        set_geometry(32'sh8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_burst(60);
        settle();
        set_geometry(32'h7FFF_FFFF, 0, 0, 0, 1, 0, 0, 0);
        random_burst(60);
        settle();
    endtask

    task automatic test_random_zero_pitch();
        set_geometry(0, 200 * CM, 200 * CM, 10 * CM, 0, 100 * CM, 3, 2);
        random_burst(140);
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        calm    = 1'b0;
        map_offset_q = 0;
        bar_zlim_q   = 0;
        ec_zstart_q  = 0;
        ec_rfloor_q  = 0;
        pitch_q      = PITCH_RESET;
        bar_depth_q  = 0;
        bar_iron_q   = 0;
        ec_gap_q     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_fill();
        test_directed();
        test_random_nominal();
        test_random_shifted();
        test_random_extremes();
        test_random_zero_pitch();

        if (errors == 0) begin
            $display("layered_field_map_evaluator test passed");
        end else begin
            $display("layered_field_map_evaluator test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lfme_pkg.sv
sv/layered_field_map_evaluator.sv
sim/layered_field_map_evaluator_tb.sv
